// File: design/assert_macros.svh
// Assertion macros used by the nearest palette color top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge while out of reset.
`define NPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define NPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/npc_pkg.sv
// Types and constants shared by the nearest palette color modules.
package npc_pkg;

  localparam int COLOR_W = 8;
  localparam int IDX_W   = 8;
  localparam int SQ_W    = 2 * COLOR_W;
  // Largest distance is 3*255*255, which fits below 2**18.
  localparam int DIST_W  = 18;
  localparam logic [DIST_W-1:0] DIST_START = 18'(256 * 256 * 3);

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_DRAIN,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic init;  // latch pixel, clear best match and scan counter
    logic wr;    // write one palette entry
    logic rd;    // read the next palette entry
  } dp_cmd_t;

  typedef struct packed {
    logic last;  // scan counter points at the final entry
  } dp_status_t;

endpackage

// File: design/npc_datapath.sv
// Palette memory, distance pipeline and running best match.
module npc_datapath #(
  parameter int PaletteSize = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  npc_pkg::dp_cmd_t              cmd_i,
  output npc_pkg::dp_status_t           status_o,
  input  logic [npc_pkg::IDX_W-1:0]     entry_index_i,
  input  logic [npc_pkg::COLOR_W-1:0]   red_i,
  input  logic [npc_pkg::COLOR_W-1:0]   green_i,
  input  logic [npc_pkg::COLOR_W-1:0]   blue_i,
  output logic [npc_pkg::IDX_W-1:0]     palette_index_o
);

  localparam int AddrW  = $clog2(PaletteSize);
  localparam int IdxW   = npc_pkg::IDX_W;
  localparam int ColorW = npc_pkg::COLOR_W;
  localparam int SqW    = npc_pkg::SQ_W;
  localparam int DistW  = npc_pkg::DIST_W;

  logic [3*ColorW-1:0] mem_q [PaletteSize];

  logic [AddrW-1:0]    cnt_q, cnt_d;
  logic [3*ColorW-1:0] rd_data_q;
  logic [AddrW-1:0]    rd_idx_q;
  logic                rd_vld_q;
  logic [ColorW-1:0]   pix_r_q, pix_g_q, pix_b_q;
  logic [SqW-1:0]      sq_r_q, sq_g_q, sq_b_q;
  logic [SqW-1:0]      sq_r_d, sq_g_d, sq_b_d;
  logic [AddrW-1:0]    sq_idx_q;
  logic                sq_vld_q;
  logic [DistW-1:0]    best_dist_q, best_dist_d;
  logic [AddrW-1:0]    best_idx_q, best_idx_d;
  logic [DistW-1:0]    dist_sum;
  logic                wr_in_range;

  assign wr_in_range = ({1'b0, entry_index_i} < (IdxW + 1)'(PaletteSize));

  // Palette memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && wr_in_range) begin
      mem_q[entry_index_i[AddrW-1:0]] <= {red_i, green_i, blue_i};
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem_q[cnt_q];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.init) begin
      cnt_d = '0;
    end else if (cmd_i.rd) begin
      cnt_d = cnt_q + AddrW'(1);
    end
  end

  assign status_o.last = (cnt_q == AddrW'(PaletteSize - 1));

  function automatic logic [SqW-1:0] sq_diff(input logic [ColorW-1:0] a,
                                             input logic [ColorW-1:0] b);
    logic [ColorW-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SqW'(d) * SqW'(d);
  endfunction

  assign sq_r_d = sq_diff(rd_data_q[3*ColorW-1:2*ColorW], pix_r_q);
  assign sq_g_d = sq_diff(rd_data_q[2*ColorW-1:ColorW], pix_g_q);
  assign sq_b_d = sq_diff(rd_data_q[ColorW-1:0], pix_b_q);

  assign dist_sum = DistW'(sq_r_q) + DistW'(sq_g_q) + DistW'(sq_b_q);

  // Strict compare keeps the lower index on a tie.
  always_comb begin
    best_dist_d = best_dist_q;
    best_idx_d  = best_idx_q;
    if (cmd_i.init) begin
      best_dist_d = npc_pkg::DIST_START;
      best_idx_d  = '0;
    end else if (sq_vld_q && (dist_sum < best_dist_q)) begin
      best_dist_d = dist_sum;
      best_idx_d  = sq_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      sq_vld_q    <= 1'b0;
      best_dist_q <= npc_pkg::DIST_START;
      best_idx_q  <= '0;
    end else begin
      cnt_q       <= cnt_d;
      rd_vld_q    <= cmd_i.rd;
      sq_vld_q    <= rd_vld_q;
      best_dist_q <= best_dist_d;
      best_idx_q  <= best_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      pix_r_q <= red_i;
      pix_g_q <= green_i;
      pix_b_q <= blue_i;
    end
    rd_idx_q <= cnt_q;
    sq_idx_q <= rd_idx_q;
    sq_r_q   <= sq_r_d;
    sq_g_q   <= sq_g_d;
    sq_b_q   <= sq_b_d;
  end

  assign palette_index_o = IdxW'(best_idx_q);

endmodule

// File: design/npc_ctrl.sv
// Sequencer for load and convert commands.
module npc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                opcode_i,
  input  npc_pkg::dp_status_t status_i,
  output npc_pkg::dp_cmd_t    cmd_o,
  output logic                busy_o,
  output logic                done_o
);

  npc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= npc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      npc_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          if (opcode_i == npc_pkg::OP_CONVERT) begin
            cmd_o.init = 1'b1;
            state_d    = npc_pkg::ST_SCAN;
          end else begin
            cmd_o.wr = 1'b1;
          end
        end
      end
      npc_pkg::ST_SCAN: begin
        cmd_o.rd = 1'b1;
        if (status_i.last) begin
          state_d = npc_pkg::ST_WAIT;
        end
      end
      // let the last entry run through the read and square stages
      npc_pkg::ST_WAIT: state_d = npc_pkg::ST_DRAIN;
      npc_pkg::ST_DRAIN: state_d = npc_pkg::ST_RESP;
      npc_pkg::ST_RESP: begin
        done_o  = 1'b1;
        state_d = npc_pkg::ST_IDLE;
      end
      default: state_d = npc_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: design/nearest_palette_color.sv
// Top level of the nearest palette color block.
//
//   port group        dir  transfer
//   start_i + fields  in   start_i high while busy_o low
//   done_o + index    out  one-cycle strobe, cannot be held off
//
// A load does not raise busy_o; the block stays ready for the next command.
// A convert keeps busy_o high through the scan, the WAIT and DRAIN states
// and the result strobe; a new command is accepted only once busy_o is low.
// The single read port of the palette memory yields one entry per cycle.
// Reset clears the controller and the match registers, not the palette.
// The result strobe done_o lasts one cycle; the receiver cannot stall.
`include "assert_macros.svh"

module nearest_palette_color #(
  parameter int PALETTE_SIZE = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        opcode_i,
  input  logic [npc_pkg::IDX_W-1:0]   entry_index_i,
  input  logic [npc_pkg::COLOR_W-1:0] red_i,
  input  logic [npc_pkg::COLOR_W-1:0] green_i,
  input  logic [npc_pkg::COLOR_W-1:0] blue_i,
  output logic                        done_o,
  output logic [npc_pkg::IDX_W-1:0]   palette_index_o
);

  npc_pkg::dp_cmd_t    cmd;
  npc_pkg::dp_status_t status;

  npc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  npc_datapath #(
    .PaletteSize (PALETTE_SIZE)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .entry_index_i   (entry_index_i),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .palette_index_o (palette_index_o)
  );

  `NPC_ASSERT(a_done_while_busy, clk_i, rst_ni, done_o |-> busy_o, "result outside a conversion")
  `NPC_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o && !busy_o, "strobe too long")
  `NPC_ASSERT_NEXT(a_convert_busy, clk_i, rst_ni, start_i && !busy_o && opcode_i == npc_pkg::OP_CONVERT, busy_o && !done_o, "convert not started")
  `NPC_ASSERT_NEXT(a_load_idle, clk_i, rst_ni, start_i && !busy_o && opcode_i == npc_pkg::OP_LOAD, !busy_o && !done_o, "load left block busy")

endmodule
